/* rtl/sqse_pkg.sv */
// Package for the stroke quad-strip expander: field widths, fixed-point
// constants and the sequencer state type. Depends on nothing.
package sqse_pkg;

  localparam int FRAC_BITS_DEF = 12;
  localparam int LEN_SHIFT     = 12;

  localparam int POS_W     = 16;
  localparam int PRES_W    = 13;
  localparam int TILT_W    = 14;
  localparam int GAIN_W    = 12;
  localparam int TEXV_W    = 24;
  localparam int VERT_W    = 14;
  localparam int ANG_W     = 15;

  localparam int DIFF_W    = POS_W + 1;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int ROOT_W    = (SQ_W + 2 * LEN_SHIFT) / 2;
  localparam int SCALE_W   = PRES_W + GAIN_W;
  localparam int TILT_SQ_W = 2 * TILT_W;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(410);
  localparam logic [TEXV_W-1:0] RUN_MAX    = {TEXV_W{1'b1}};
  localparam logic [VERT_W-1:0] VERT_MAX   = {VERT_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_ROOT_WAIT,
    ST_DIV,
    ST_DIV_WAIT,
    ST_MUL1,
    ST_MUL2,
    ST_FIN,
    ST_EMIT_L,
    ST_EMIT_R
  } state_t;

endpackage

/* rtl/sqse_isqrt.sv */
// Bit-serial integer square root, two radicand bits per cycle.
// Uses no package items; instantiated by the expander top level.
module sqse_isqrt #(
  parameter int ROOT_W = 29
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic [ROOT_W-1:0]     root,
  output logic                  done
);

  localparam int CNT_W = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [2*ROOT_W-1:0] rad_r;
  logic [ROOT_W:0]     rem_r;
  logic [ROOT_W-1:0]   root_r;

  logic [ROOT_W+2:0]   rem_sh;
  logic [ROOT_W+2:0]   trial;
  logic [ROOT_W+2:0]   diff;
  logic                ge;
  logic [ROOT_W:0]     rem_nxt;
  logic [ROOT_W-1:0]   root_nxt;

  always_comb begin
    rem_sh   = {rem_r, rad_r[2*ROOT_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    diff     = rem_sh - trial;
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
    root_nxt = {root_r[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_W - 1);
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r  <= {rad_r[2*ROOT_W-3:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

/* rtl/sqse_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses no package items; instantiated twice by the expander top level.
module sqse_div #(
  parameter int W   = 42,
  parameter int Q_W = 14
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   num,
  input  logic [W-1:0]   den,
  output logic [Q_W-1:0] quot,
  output logic           done
);

  localparam int CNT_W = (Q_W > 1) ? $clog2(Q_W) : 1;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     dsh_r;
  logic [Q_W-1:0]   q_r;
  logic             ge;

  assign ge = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(Q_W - 1);
        rem_r  <= num;
        dsh_r  <= den << (Q_W - 1);
        q_r    <= '0;
      end else if (busy_r) begin
        if (ge) begin
          rem_r <= rem_r - dsh_r;
        end
        q_r   <= {q_r[Q_W-2:0], ge};
        dsh_r <= dsh_r >> 1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign quot = q_r;
  assign done = done_r;

endmodule

/* rtl/stroke_quad_strip_expander_core.sv */
// Top level of the stroke quad-strip expander: sequencer, multipliers and rounding.
// Depends on sqse_pkg, sqse_isqrt and sqse_div.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------
//  cfg      | in        | cfg_we               | cfg_width_gain
//  in       | in        | in_valid / in_ready  | start, pos x/y, pressure, tilt x/y
//  out      | out       | out_valid / out_ready| vertex, u/v, tilt terms, pair flag
//
// A sample that opens a stroke leaves the sequencer in ST_IDLE. One that continues
// a stroke runs the sequencer through every state and both vertex beats before the
// next one is accepted; the 29-step serial square root and the FRAC_BITS + 2 step
// serial dividers make up most of that run, and output stall lengthens it.
// Reset clears the stroke state and loads the default width gain.
// One item is worked on at a time; in_ready is low until both vertex beats leave.
module stroke_quad_strip_expander_core #(
  parameter int FRAC_BITS = sqse_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sqse_pkg::GAIN_W-1:0]         cfg_width_gain,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_start_of_stroke,
  input  logic signed [sqse_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [sqse_pkg::POS_W-1:0]   in_pos_y,
  input  logic [sqse_pkg::PRES_W-1:0]         in_pen_pressure,
  input  logic signed [sqse_pkg::TILT_W-1:0]  in_tilt_x,
  input  logic signed [sqse_pkg::TILT_W-1:0]  in_tilt_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sqse_pkg::POS_W-1:0]   out_vert_x,
  output logic signed [sqse_pkg::POS_W-1:0]   out_vert_y,
  output logic [sqse_pkg::PRES_W-1:0]         out_vert_z,
  output logic                                out_tex_u,
  output logic [sqse_pkg::TEXV_W-1:0]         out_tex_v,
  output logic [sqse_pkg::VERT_W-1:0]         out_verticalness,
  output logic signed [sqse_pkg::ANG_W-1:0]   out_stroke_angle,
  output logic                                out_last_of_pair
);

  import sqse_pkg::*;

  // Unit perpendicular components span plus and minus one in Q.FRAC_BITS.
  localparam int N_W   = FRAC_BITS + 2;
  localparam int Q_W   = FRAC_BITS + 2;
  localparam int DIV_W = FRAC_BITS + 30;
  localparam int OP_W  = FRAC_BITS + 28;
  localparam int VW    = OP_W + 2;
  localparam int AP_W  = FRAC_BITS + 17;
  localparam int AW    = AP_W + 2;
  localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;

  // Saturate a wide signed sum to the vertex coordinate range.
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] hi;
    logic signed [VW-1:0] lo;
    hi = VW'({1'b0, {(POS_W-1){1'b1}}});
    lo = -hi - VW'(1);
    if (v > hi) begin
      sat_pos = hi[POS_W-1:0];
    end else if (v < lo) begin
      sat_pos = lo[POS_W-1:0];
    end else begin
      sat_pos = v[POS_W-1:0];
    end
  endfunction

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0]         gain_r;
  logic                      have_prev_r;
  logic signed [POS_W-1:0]   prev_x_r, prev_y_r;
  logic [PRES_W-1:0]         prev_p_r;
  logic signed [TILT_W-1:0]  prev_tx_r, prev_ty_r;
  logic [TEXV_W-1:0]         run_r;

  // The point that the current segment is built around.
  logic signed [POS_W-1:0]   pt_x_r, pt_y_r;
  logic [PRES_W-1:0]         pt_p_r;
  logic signed [TILT_W-1:0]  pt_tx_r, pt_ty_r;

  logic signed [DIFF_W-1:0]  dx_r, dy_r;
  logic [SQ_W-1:0]           sq_r;
  logic [TILT_SQ_W-1:0]      vsq_r;
  logic [SCALE_W-1:0]        scale_r;
  logic signed [N_W-1:0]     nx_r, ny_r;
  logic signed [AP_W-1:0]    angp_r;
  logic signed [OP_W-1:0]    oxp_r, oyp_r;

  logic signed [POS_W-1:0]   vxl_r, vxr_r, vyl_r, vyr_r;
  logic [VERT_W-1:0]         vert_r;
  logic signed [ANG_W-1:0]   ang_r;

  logic                      in_acc;
  logic                      sqrt_start, sqrt_done;
  logic                      div_start, divx_done, divy_done;
  logic [ROOT_W-1:0]         lh;
  logic [Q_W-1:0]            qx, qy;

  // Handshake and sequencing.
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && have_prev_r && !in_start_of_stroke) begin
          state_nxt = ST_SQX;
        end
      end
      ST_SQX:  state_nxt = ST_SQY;
      ST_SQY:  state_nxt = ST_ROOT;
      ST_ROOT: begin
        sqrt_start = 1'b1;
        state_nxt  = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (sqrt_done) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (divx_done && divy_done) begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_EMIT_L;
      ST_EMIT_L: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_EMIT_R;
        end
      end
      ST_EMIT_R: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Serial arithmetic units. Both dividers start together and finish together;
  // the sequencer waits for both done flags.
  sqse_isqrt #(
    .ROOT_W (ROOT_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand ({sq_r, {(2*LEN_SHIFT){1'b0}}}),
    .root     (lh),
    .done     (sqrt_done)
  );

  logic [DIFF_W-1:0] mag_dx, mag_dy;
  logic [DIV_W-1:0]  num_x, num_y, den;

  always_comb begin
    mag_dx = dx_r[DIFF_W-1] ? DIFF_W'(-dx_r) : DIFF_W'(dx_r);
    mag_dy = dy_r[DIFF_W-1] ? DIFF_W'(-dy_r) : DIFF_W'(dy_r);
    den    = DIV_W'(lh);
    // Numerators carry half the divisor so the quotient rounds to nearest.
    num_x  = (DIV_W'(mag_dy) << (FRAC_BITS + LEN_SHIFT)) + DIV_W'(lh >> 1);
    num_y  = (DIV_W'(mag_dx) << (FRAC_BITS + LEN_SHIFT)) + DIV_W'(lh >> 1);
  end

  sqse_div #(
    .W   (DIV_W),
    .Q_W (Q_W)
  ) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_x),
    .den   (den),
    .quot  (qx),
    .done  (divx_done)
  );

  sqse_div #(
    .W   (DIV_W),
    .Q_W (Q_W)
  ) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_y),
    .den   (den),
    .quot  (qy),
    .done  (divy_done)
  );

  // Stroke length: the half segment is rounded and the sum saturates.
  logic [ROOT_W:0]   half_sum;
  logic [TEXV_W:0]   run_sum;
  logic [Q_W-1:0]    qx_sat, qy_sat;

  always_comb begin
    half_sum = (ROOT_W+1)'(lh) + ((ROOT_W+1)'(1) << LEN_SHIFT);
    run_sum  = (TEXV_W+1)'(run_r) + (TEXV_W+1)'(half_sum >> (LEN_SHIFT + 1));
    qx_sat   = (qx > ONE_Q) ? ONE_Q : qx;
    qy_sat   = (qy > ONE_Q) ? ONE_Q : qy;
  end

  // Products; sq_r, vsq_r and angp_r each take two of them, one per state.
  logic signed [SQ_W-1:0]      dxsq, dysq;
  logic signed [TILT_SQ_W-1:0] txsq, tysq;
  logic signed [AP_W-1:0]      angx, angy;
  logic signed [OP_W-1:0]      oxp, oyp;
  logic signed [SCALE_W:0]     scale_s;

  always_comb begin
    scale_s = $signed({1'b0, scale_r});
    dxsq    = dx_r * dx_r;
    dysq    = dy_r * dy_r;
    txsq    = pt_tx_r * pt_tx_r;
    tysq    = pt_ty_r * pt_ty_r;
    angx    = pt_tx_r * nx_r;
    angy    = pt_ty_r * ny_r;
    oxp     = nx_r * scale_s;
    oyp     = ny_r * scale_s;
  end

  // Final rounding, ties away from zero, and saturation.
  logic [OP_W-1:0]       oxm, oym;
  logic [OP_W:0]         oxr, oyr;
  logic signed [VW-1:0]  oxs, oys;
  logic [AP_W-1:0]       angm;
  logic [AP_W:0]         angr;
  logic signed [AW-1:0]  angs;
  logic [TILT_SQ_W:0]    vrnd;
  logic signed [AW-1:0]  ang_hi, ang_lo;

  always_comb begin
    oxm    = oxp_r[OP_W-1] ? OP_W'(-oxp_r) : OP_W'(oxp_r);
    oym    = oyp_r[OP_W-1] ? OP_W'(-oyp_r) : OP_W'(oyp_r);
    oxr    = ((OP_W+1)'(oxm) + ((OP_W+1)'(1) << (2*FRAC_BITS - 1))) >> (2*FRAC_BITS);
    oyr    = ((OP_W+1)'(oym) + ((OP_W+1)'(1) << (2*FRAC_BITS - 1))) >> (2*FRAC_BITS);
    oxs    = oxp_r[OP_W-1] ? -$signed(VW'(oxr)) : $signed(VW'(oxr));
    oys    = oyp_r[OP_W-1] ? -$signed(VW'(oyr)) : $signed(VW'(oyr));
    angm   = angp_r[AP_W-1] ? AP_W'(-angp_r) : AP_W'(angp_r);
    angr   = ((AP_W+1)'(angm) + ((AP_W+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    angs   = angp_r[AP_W-1] ? -$signed(AW'(angr)) : $signed(AW'(angr));
    ang_hi = AW'({1'b0, {(ANG_W-1){1'b1}}});
    ang_lo = -ang_hi - AW'(1);
    vrnd   = ((TILT_SQ_W+1)'(vsq_r) + ((TILT_SQ_W+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  end

  // Stroke state and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_RESET;
      have_prev_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_p_r    <= '0;
      prev_tx_r   <= '0;
      prev_ty_r   <= '0;
      run_r       <= '0;
    end else begin
      if (cfg_we) begin
        gain_r <= cfg_width_gain;
      end
      if (in_acc) begin
        // The old point moves to the work registers; the new one is kept.
        pt_x_r      <= prev_x_r;
        pt_y_r      <= prev_y_r;
        pt_p_r      <= prev_p_r;
        pt_tx_r     <= prev_tx_r;
        pt_ty_r     <= prev_ty_r;
        dx_r        <= DIFF_W'(in_pos_x) - DIFF_W'(prev_x_r);
        dy_r        <= DIFF_W'(in_pos_y) - DIFF_W'(prev_y_r);
        prev_x_r    <= in_pos_x;
        prev_y_r    <= in_pos_y;
        prev_p_r    <= in_pen_pressure;
        prev_tx_r   <= in_tilt_x;
        prev_ty_r   <= in_tilt_y;
        have_prev_r <= 1'b1;
        if (in_start_of_stroke) begin
          run_r <= '0;
        end
      end
      if (state_r == ST_DIV) begin
        run_r <= run_sum[TEXV_W] ? RUN_MAX : run_sum[TEXV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_SQX: begin
        sq_r    <= SQ_W'(unsigned'(dxsq));
        vsq_r   <= TILT_SQ_W'(unsigned'(txsq));
        scale_r <= SCALE_W'(pt_p_r * gain_r);
      end
      ST_SQY: begin
        sq_r  <= sq_r + SQ_W'(unsigned'(dysq));
        vsq_r <= vsq_r + TILT_SQ_W'(unsigned'(tysq));
      end
      ST_DIV_WAIT: begin
        if (divx_done && divy_done) begin
          // A zero-length segment has no perpendicular.
          if (lh == '0) begin
            nx_r <= '0;
            ny_r <= '0;
          end else begin
            nx_r <= (dy_r > 0) ? -$signed(N_W'(qx_sat)) : $signed(N_W'(qx_sat));
            ny_r <= dx_r[DIFF_W-1] ? -$signed(N_W'(qy_sat)) : $signed(N_W'(qy_sat));
          end
        end
      end
      ST_MUL1: begin
        angp_r <= angx;
        oxp_r  <= oxp;
      end
      ST_MUL2: begin
        angp_r <= angp_r + angy;
        oyp_r  <= oyp;
      end
      ST_FIN: begin
        vxl_r  <= sat_pos(VW'(pt_x_r) - oxs);
        vxr_r  <= sat_pos(VW'(pt_x_r) + oxs);
        vyl_r  <= sat_pos(VW'(pt_y_r) - oys);
        vyr_r  <= sat_pos(VW'(pt_y_r) + oys);
        vert_r <= (vrnd > (TILT_SQ_W+1)'(VERT_MAX)) ? VERT_MAX : vrnd[VERT_W-1:0];
        if (angs > ang_hi) begin
          ang_r <= ang_hi[ANG_W-1:0];
        end else if (angs < ang_lo) begin
          ang_r <= ang_lo[ANG_W-1:0];
        end else begin
          ang_r <= angs[ANG_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Left vertex beat first, then right.
  assign out_tex_u        = (state_r == ST_EMIT_R);
  assign out_last_of_pair = (state_r == ST_EMIT_R);
  assign out_vert_x       = (state_r == ST_EMIT_R) ? vxr_r : vxl_r;
  assign out_vert_y       = (state_r == ST_EMIT_R) ? vyr_r : vyl_r;
  assign out_vert_z       = pt_p_r;
  assign out_tex_v        = run_r;
  assign out_verticalness = vert_r;
  assign out_stroke_angle = ang_r;

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for stroke_quad_strip_expander_core.
// It depends on sqse_pkg and the core RTL. An in-bench model of the stroke
// geometry predicts every vertex beat, and each beat is checked against it.
module tb_top;
  import sqse_pkg::*;

  // One pen sample as it is driven on the input channel.
  typedef struct {
    logic                     start;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic [PRES_W-1:0]        p;
    logic signed [TILT_W-1:0] tx;
    logic signed [TILT_W-1:0] ty;
  } sample_t;

  // One emitted vertex, field by field as it leaves the block.
  typedef struct {
    logic signed [POS_W-1:0] vx;
    logic signed [POS_W-1:0] vy;
    logic [PRES_W-1:0]       vz;
    logic                    u;
    logic [TEXV_W-1:0]       v;
    logic [VERT_W-1:0]       vert;
    logic signed [ANG_W-1:0] ang;
    logic                    last;
  } vertex_t;

  localparam longint ONE = longint'(1) << FRAC_BITS_DEF;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [GAIN_W-1:0] cfg_width_gain;
  logic in_valid;
  logic in_ready;
  logic in_start_of_stroke;
  logic signed [POS_W-1:0] in_pos_x, in_pos_y;
  logic [PRES_W-1:0] in_pen_pressure;
  logic signed [TILT_W-1:0] in_tilt_x, in_tilt_y;
  logic out_valid;
  logic out_ready;
  logic signed [POS_W-1:0] out_vert_x, out_vert_y;
  logic [PRES_W-1:0] out_vert_z;
  logic out_tex_u;
  logic [TEXV_W-1:0] out_tex_v;
  logic [VERT_W-1:0] out_verticalness;
  logic signed [ANG_W-1:0] out_stroke_angle;
  logic out_last_of_pair;

  // Idle percentages for the sender and the receiver; changed per phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Vertices predicted but not yet seen on the output channel.
  vertex_t pending_vertices[$];
  int mismatch_count = 0;
  int beats_checked = 0;
  int samples_sent = 0;

  // Shadow of the stroke state and the width gain register.
  longint unsigned gain_shadow;
  bit      stroke_open;
  longint  last_x, last_y, last_tx, last_ty;
  longint  last_p;
  longint  stroke_len;

  always #5 clk = ~clk;

  stroke_quad_strip_expander_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_width_gain     (cfg_width_gain),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_start_of_stroke (in_start_of_stroke),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pen_pressure    (in_pen_pressure),
    .in_tilt_x          (in_tilt_x),
    .in_tilt_y          (in_tilt_y),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_vert_x         (out_vert_x),
    .out_vert_y         (out_vert_y),
    .out_vert_z         (out_vert_z),
    .out_tex_u          (out_tex_u),
    .out_tex_v          (out_tex_v),
    .out_verticalness   (out_verticalness),
    .out_stroke_angle   (out_stroke_angle),
    .out_last_of_pair   (out_last_of_pair)
  );

  // Round to nearest with ties away from zero; the divisor is positive.
  function automatic longint round_div(longint num, longint den);
    longint unsigned mag;
    longint q;
    mag = (num < 0) ? longint'(-num) : num;
    q = longint'((mag + longint'(den) / 2) / den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Bit-serial integer square root, floor of the true root.
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Advance the stroke shadow by one accepted sample. A sample that continues
  // a stroke yields the left and the right vertex around the previous point.
  function automatic void advance_stroke(sample_t s);
    longint dx, dy, nx, ny, vert, ang, scale, ox, oy, vx, vy, sgn;
    longint unsigned sq, lh, half;
    vertex_t e;
    if (s.start) begin
      stroke_open = 1'b0;
      stroke_len = 0;
    end
    if (stroke_open) begin
      dx = longint'(s.x) - last_x;
      dy = longint'(s.y) - last_y;
      sq = dx * dx + dy * dy;
      lh = floor_sqrt(sq << (2 * LEN_SHIFT));
      half = (lh + (64'd1 << LEN_SHIFT)) >> (LEN_SHIFT + 1);
      stroke_len = clamp(stroke_len + longint'(half), 0, 16777215);
      nx = 0;
      ny = 0;
      // A zero-length segment leaves the perpendicular at zero.
      if (lh != 0) begin
        nx = clamp(round_div(-dy * ONE * (longint'(1) << LEN_SHIFT), lh), -ONE, ONE);
        ny = clamp(round_div(dx * ONE * (longint'(1) << LEN_SHIFT), lh), -ONE, ONE);
      end
      vert = clamp(round_div(last_tx * last_tx + last_ty * last_ty, ONE), 0, 16383);
      ang = clamp(round_div(last_tx * nx + last_ty * ny, ONE), -16384, 16383);
      scale = last_p * longint'(gain_shadow);
      ox = round_div(nx * scale, longint'(1) << (2 * FRAC_BITS_DEF));
      oy = round_div(ny * scale, longint'(1) << (2 * FRAC_BITS_DEF));
      for (int k = 0; k < 2; k++) begin
        sgn = k ? 1 : -1;
        vx = clamp(last_x + sgn * ox, -32768, 32767);
        vy = clamp(last_y + sgn * oy, -32768, 32767);
        e.vx = vx[POS_W-1:0];
        e.vy = vy[POS_W-1:0];
        e.vz = last_p[PRES_W-1:0];
        e.u = k[0];
        e.v = stroke_len[TEXV_W-1:0];
        e.vert = vert[VERT_W-1:0];
        e.ang = ang[ANG_W-1:0];
        e.last = k[0];
        pending_vertices = {pending_vertices, e};
      end
    end
    last_x = s.x;
    last_y = s.y;
    last_p = s.p;
    last_tx = s.tx;
    last_ty = s.ty;
    stroke_open = 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // Output side: random backpressure, and every accepted beat is compared
  // with the oldest predicted vertex.
  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && out_valid && out_ready) begin
      beats_checked++;
      if (pending_vertices.size() == 0) begin
        report_mismatch("vertex beat with nothing predicted");
      end else begin
        e = pending_vertices.pop_front();
        if (out_vert_x !== e.vx)
          report_mismatch($sformatf("vert_x %0d want %0d", out_vert_x, e.vx));
        if (out_vert_y !== e.vy)
          report_mismatch($sformatf("vert_y %0d want %0d", out_vert_y, e.vy));
        if (out_vert_z !== e.vz)
          report_mismatch($sformatf("vert_z %0d want %0d", out_vert_z, e.vz));
        if (out_tex_u !== e.u)
          report_mismatch($sformatf("tex_u %0d want %0d", out_tex_u, e.u));
        if (out_tex_v !== e.v)
          report_mismatch($sformatf("tex_v %0d want %0d", out_tex_v, e.v));
        if (out_verticalness !== e.vert)
          report_mismatch($sformatf("verticalness %0d want %0d",
                                    out_verticalness, e.vert));
        if (out_stroke_angle !== e.ang)
          report_mismatch($sformatf("stroke_angle %0d want %0d",
                                    out_stroke_angle, e.ang));
        if (out_last_of_pair !== e.last)
          report_mismatch($sformatf("last_of_pair %0d want %0d",
                                    out_last_of_pair, e.last));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic sample_t make_sample(bit st, int x, int y, int p, int tx, int ty);
    sample_t s;
    s.start = st;
    s.x = x[POS_W-1:0];
    s.y = y[POS_W-1:0];
    s.p = p[PRES_W-1:0];
    s.tx = tx[TILT_W-1:0];
    s.ty = ty[TILT_W-1:0];
    return s;
  endfunction

  // Send one sample beat. It is called at a rising edge; valid stays high
  // from the previous beat unless a random gap is inserted first.
  task automatic send_sample(sample_t s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_of_stroke <= s.start;
    in_pos_x <= s.x;
    in_pos_y <= s.y;
    in_pen_pressure <= s.p;
    in_tilt_x <= s.tx;
    in_tilt_y <= s.ty;
    do @(posedge clk); while (!in_ready);
    advance_stroke(s);
    samples_sent++;
  endtask

  // Drop valid, wait for every predicted vertex, then let the block settle.
  // A sample that opens a stroke emits nothing, so the pause covers it too.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_width_gain(logic [GAIN_W-1:0] g);
    drain_block();
    cfg_we <= 1'b1;
    cfg_width_gain <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    gain_shadow = g;
  endtask

  // Extremes of every field and the special cases: a continuation right after
  // reset, zero-length segments, restarts, full-span jumps and saturating
  // vertices, pressure and tilt codes beyond their nominal range.
  task automatic test_directed();
    send_sample(make_sample(0, 10, 20, 100, 0, 0));
    send_sample(make_sample(1, 0, 0, 4096, 4096, 0));
    send_sample(make_sample(0, 0, 0, 4096, 0, 4096));
    send_sample(make_sample(0, 4096, 0, 0, -4096, 4096));
    send_sample(make_sample(0, 32767, 32767, 8191, 8191, -8192));
    send_sample(make_sample(0, -32768, -32768, 4096, -8192, -8192));
    send_sample(make_sample(0, 32767, -32768, 4096, 0, 0));
    send_sample(make_sample(0, 0, 1, 1, 1, -1));
    send_sample(make_sample(0, 1, 1, 4096, 4096, 4096));
    send_sample(make_sample(1, 100, 100, 2048, 100, -100));
    send_sample(make_sample(0, 100, 4196, 2048, -4096, -4096));
    send_sample(make_sample(1, 32767, 0, 4096, 8191, 8191));
    send_sample(make_sample(0, 32767, 4096, 8191, 0, 8191));
    send_sample(make_sample(0, 32766, 4096, 4096, -8192, 0));
    send_sample(make_sample(0, -32768, 0, 4096, 2000, -3000));
    send_sample(make_sample(0, -32768, 0, 8191, 4096, 0));
    send_sample(make_sample(0, -32767, 32767, 0, 0, 0));
  endtask

  // Well-formed strokes: a start sample followed by small steps, with an
  // occasional repeated point or large jump, and mostly nominal codes.
  task automatic test_strokes(int n_items);
    int cnt, len;
    int x, y, p, tx, ty;
    cnt = 0;
    while (cnt < n_items) begin
      len = $urandom_range(1, 14);
      x = $signed(16'($urandom));
      y = $signed(16'($urandom));
      for (int i = 0; i < len && cnt < n_items; i++) begin
        case ($urandom_range(9))
          0: begin
            x = $signed(16'($urandom));
            y = $signed(16'($urandom));
          end
          1: ;
          default: begin
            x = $signed(16'(x + $urandom_range(0, 2048) - 1024));
            y = $signed(16'(y + $urandom_range(0, 2048) - 1024));
          end
        endcase
        p = ($urandom_range(9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 4096);
        if ($urandom_range(9) == 0) begin
          tx = $signed(14'($urandom));
          ty = $signed(14'($urandom));
        end else begin
          tx = $urandom_range(0, 8192) - 4096;
          ty = $urandom_range(0, 8192) - 4096;
        end
        send_sample(make_sample(i == 0, x, y, p, tx, ty));
        cnt++;
      end
    end
  endtask

  // Unstructured samples: every field fully random, start flag included.
  task automatic test_noise(int n_items);
    for (int i = 0; i < n_items; i++)
      send_sample(make_sample($urandom_range(1), $urandom, $urandom, $urandom,
                              $urandom, $urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_width_gain = '0;
    in_valid = 1'b0;
    in_start_of_stroke = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pen_pressure = '0;
    in_tilt_x = '0;
    in_tilt_y = '0;
    out_ready = 1'b0;
    gain_shadow = 410;
    stroke_open = 1'b0;
    last_x = 0;
    last_y = 0;
    last_p = 0;
    last_tx = 0;
    last_ty = 0;
    stroke_len = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default gain from reset first, then the largest gain.
    test_directed();
    write_width_gain(12'd4095);
    send_idle_pct = 34;
    recv_idle_pct = 84;
    test_directed();
    test_strokes(170);
    test_noise(30);

    write_width_gain(12'd0);
    send_idle_pct = 84;
    recv_idle_pct = 34;
    test_strokes(170);
    test_noise(30);

    write_width_gain(12'($urandom_range(1, 4094)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_strokes(170);
    test_noise(30);

    drain_block();
    $display("Covered %0d samples and %0d vertex beats over four width gains,",
             samples_sent, beats_checked);
    $display("three idle patterns, directed extremes and random strokes.");
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
